// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the regulator RTL.
// No dependencies; compiled away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent is followed by a consequent on the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/core/ldr_pkg.sv -----
// Shared types and constants for the LED current DAC regulator.
// No dependencies; used by every RTL file of the block except assert_macros.svh.
package ldr_pkg;

  localparam int LDR_HIST_DEPTH = 16;
  localparam int SAMPLE_W       = 15;
  localparam int RAW_W          = 16;
  localparam int DAC_W          = 12;
  localparam int STEP_W         = 6;
  localparam int DIFF_W         = SAMPLE_W - 3;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 15;

  localparam logic [STEP_W-1:0]   STEP_RESET    = 6'd32;
  localparam logic [STEP_W-1:0]   STEP_MIN      = 6'd1;
  localparam logic [DAC_W-1:0]    DAC_RESET     = 12'd4095;
  localparam logic [SAMPLE_W-1:0] TARGET1_RESET = 15'd0;
  localparam logic [SAMPLE_W-1:0] TARGET2_RESET = 15'd1500;
  localparam logic [SAMPLE_W-1:0] TARGET3_RESET = 15'd7350;
  localparam logic [DAC_W-1:0]    FLOOR_RESET   = 12'd2048;
  localparam logic [DAC_W-1:0]    CEILING_RESET = 12'd4095;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_FLOOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_CEILING  = 3'd4;

  // Light level codes
  localparam logic [1:0] LEVEL_OFF   = 2'd0;
  localparam logic [1:0] LEVEL_ONE   = 2'd1;
  localparam logic [1:0] LEVEL_TWO   = 2'd2;
  localparam logic [1:0] LEVEL_THREE = 2'd3;

  // One control tick as seen by the DAC loop
  typedef struct packed {
    logic                advance;
    logic [SAMPLE_W-1:0] target;
    logic [SAMPLE_W-1:0] sample;
    logic [SAMPLE_W-1:0] past;
  } tick_t;

endpackage

// ----- rtl/core/ldr_in_if.sv -----
// Input channel of the regulator: handshake plus one control tick word.
// Depends on ldr_pkg for field widths.
interface ldr_in_if;
  logic                         valid;
  logic                         ready;
  logic                         link_ok;
  logic                         level_down;
  logic                         level_up;
  logic signed [ldr_pkg::RAW_W-1:0] current_sample;

  modport source (output valid, link_ok, level_down, level_up, current_sample, input ready);
  modport sink   (input valid, link_ok, level_down, level_up, current_sample, output ready);
endinterface

// ----- rtl/core/ldr_out_if.sv -----
// Result channel of the regulator: handshake plus one result word.
// Depends on ldr_pkg for field widths.
interface ldr_out_if;
  logic                       valid;
  logic                       ready;
  logic [ldr_pkg::DAC_W-1:0]  dac_code;
  logic                       converter_enable;
  logic [1:0]                 light_level;

  modport source (output valid, dac_code, converter_enable, light_level, input ready);
  modport sink   (input valid, dac_code, converter_enable, light_level, output ready);
endinterface

// ----- rtl/core/led_current_dac_regulator.sv -----
// LED current regulator: an accepted word's result word is offered in the next cycle.
// Throughput one word per cycle while results are taken; the update of level, step size and
// DAC code closes on itself each tick; the output register frees once its word is taken.
// Reset (rst_n, synchronous, active low): level 0, step 32, DAC code 4095, history cleared,
// configuration registers to their defaults, no result pending.
// Depends on ldr_pkg, ldr_in_if, ldr_out_if, ldr_hist_cell, ldr_dac_loop, assert_macros.svh.
`include "assert_macros.svh"
module led_current_dac_regulator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ldr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ldr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ldr_in_if.sink                         in_chan,
  ldr_out_if.source                      out_chan
);

  // Configuration registers
  logic [ldr_pkg::SAMPLE_W-1:0] target1_r, target2_r, target3_r;
  logic [ldr_pkg::DAC_W-1:0]    floor_r, ceiling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target1_r <= ldr_pkg::TARGET1_RESET;
      target2_r <= ldr_pkg::TARGET2_RESET;
      target3_r <= ldr_pkg::TARGET3_RESET;
      floor_r   <= ldr_pkg::FLOOR_RESET;
      ceiling_r <= ldr_pkg::CEILING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ldr_pkg::CFG_TARGET_ONE:   target1_r <= cfg_wdata[ldr_pkg::SAMPLE_W-1:0];
        ldr_pkg::CFG_TARGET_TWO:   target2_r <= cfg_wdata[ldr_pkg::SAMPLE_W-1:0];
        ldr_pkg::CFG_TARGET_THREE: target3_r <= cfg_wdata[ldr_pkg::SAMPLE_W-1:0];
        ldr_pkg::CFG_DAC_FLOOR:    floor_r   <= cfg_wdata[ldr_pkg::DAC_W-1:0];
        ldr_pkg::CFG_DAC_CEILING:  ceiling_r <= cfg_wdata[ldr_pkg::DAC_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // Handshake: take a new word whenever the output register is empty or being emptied
  logic out_valid_r;
  logic in_acc;
  logic advance;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign advance       = in_acc && in_chan.link_ok;

  // Button edges step the light level: down first, then up
  logic [1:0] level_r, level_nxt, level_dn;
  logic       down_seen_r, down_seen_nxt;
  logic       up_seen_r, up_seen_nxt;

  always_comb begin
    level_dn = level_r;
    if (in_chan.level_down && !down_seen_r && (level_r != ldr_pkg::LEVEL_OFF)) begin
      level_dn = level_r - 2'd1;
    end
    level_nxt     = level_r;
    down_seen_nxt = down_seen_r;
    up_seen_nxt   = up_seen_r;
    if (advance) begin
      level_nxt = level_dn;
      if (in_chan.level_up && !up_seen_r && (level_dn != ldr_pkg::LEVEL_THREE)) begin
        level_nxt = level_dn + 2'd1;
      end
      down_seen_nxt = in_chan.level_down;
      up_seen_nxt   = in_chan.level_up;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= ldr_pkg::LEVEL_OFF;
      down_seen_r <= 1'b0;
      up_seen_r   <= 1'b0;
    end else begin
      level_r     <= level_nxt;
      down_seen_r <= down_seen_nxt;
      up_seen_r   <= up_seen_nxt;
    end
  end

  // Target current for the new level; level off means zero target
  logic [ldr_pkg::SAMPLE_W-1:0] target;

  always_comb begin
    case (level_nxt)
      ldr_pkg::LEVEL_ONE:   target = target1_r;
      ldr_pkg::LEVEL_TWO:   target = target2_r;
      ldr_pkg::LEVEL_THREE: target = target3_r;
      default:              target = '0;
    endcase
  end

  // Negative samples count as zero, both for control and for the history
  logic [ldr_pkg::SAMPLE_W-1:0] sample;

  assign sample = in_chan.current_sample[ldr_pkg::RAW_W-1] ? '0
                : in_chan.current_sample[ldr_pkg::SAMPLE_W-1:0];

  // History line: a row of cells, advanced once per live tick; the last cell
  // holds the sample taken a full history depth ago
  logic [ldr_pkg::SAMPLE_W-1:0] hist_q [ldr_pkg::LDR_HIST_DEPTH];

  for (genvar k = 0; k < ldr_pkg::LDR_HIST_DEPTH; k++) begin : g_hist
    if (k == 0) begin : g_head
      ldr_hist_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (advance),
        .din   (sample),
        .dout  (hist_q[k])
      );
    end else begin : g_body
      ldr_hist_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (advance),
        .din   (hist_q[k-1]),
        .dout  (hist_q[k])
      );
    end
  end

  // DAC control loop
  ldr_pkg::tick_t            tick;
  logic [ldr_pkg::DAC_W-1:0] dac_nxt;

  always_comb begin
    tick.advance = advance;
    tick.target  = target;
    tick.sample  = sample;
    tick.past    = hist_q[ldr_pkg::LDR_HIST_DEPTH-1];
  end

  ldr_dac_loop u_loop (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .dac_floor   (floor_r),
    .dac_ceiling (ceiling_r),
    .dac_nxt     (dac_nxt)
  );

  // Output register: hold the result word until it is taken
  logic [ldr_pkg::DAC_W-1:0] out_dac_r;
  logic                      out_en_r;
  logic [1:0]                out_level_r;
  logic                      out_valid_nxt;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_dac_r   <= dac_nxt;
      out_en_r    <= in_chan.link_ok && (level_nxt != ldr_pkg::LEVEL_OFF);
      out_level_r <= level_nxt;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.dac_code         = out_dac_r;
  assign out_chan.converter_enable = out_en_r;
  assign out_chan.light_level      = out_level_r;

  `ASSERT_NEXT(a_acc_gives_word, clk, rst_n, in_acc, out_valid_r, "accepted word produced no result")
  `ASSERT_NEXT(a_level_hold, clk, rst_n, !advance, $stable(level_r) && $stable(down_seen_r) && $stable(up_seen_r), "level state moved without a live tick")
  `ASSERT_PROP(a_enable_level, clk, rst_n, !(out_valid_r && out_en_r) || (out_level_r != ldr_pkg::LEVEL_OFF), "converter enabled at level off")

endmodule

// ----- rtl/core/ldr_hist_cell.sv -----
// One cell of the sample history line: holds a sample, hands it on.
// Depends on ldr_pkg.
module ldr_hist_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         shift,
  input  logic [ldr_pkg::SAMPLE_W-1:0] din,
  output logic [ldr_pkg::SAMPLE_W-1:0] dout
);

  logic [ldr_pkg::SAMPLE_W-1:0] q_r;
  logic [ldr_pkg::SAMPLE_W-1:0] q_nxt;

  always_comb begin
    q_nxt = shift ? din : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign dout = q_r;

endmodule

// ----- rtl/core/ldr_dac_loop.sv -----
// Step size adaptation, current prediction and clamped DAC code update.
// Depends on ldr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ldr_dac_loop (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ldr_pkg::tick_t            tick,
  input  logic [ldr_pkg::DAC_W-1:0] dac_floor,
  input  logic [ldr_pkg::DAC_W-1:0] dac_ceiling,
  output logic [ldr_pkg::DAC_W-1:0] dac_nxt
);

  localparam int PRED_W = ldr_pkg::SAMPLE_W + 3;
  localparam int SUM_W  = ldr_pkg::DAC_W + 1;

  logic [ldr_pkg::STEP_W-1:0]   step_r;
  logic [ldr_pkg::STEP_W-1:0]   step_nxt;
  logic [ldr_pkg::STEP_W-1:0]   step_upd;
  logic [ldr_pkg::DAC_W-1:0]    dac_r;
  logic [ldr_pkg::DAC_W-1:0]    dac_upd;
  logic [ldr_pkg::SAMPLE_W-1:0] gap;
  logic [ldr_pkg::DIFF_W-1:0]   diff;
  logic signed [PRED_W-1:0]     pred_full;
  logic [PRED_W-2:0]            pred;
  logic signed [SUM_W-1:0]      dac_down;
  logic [SUM_W-1:0]             dac_up;
  logic                         overshoot;

  always_comb begin
    overshoot = tick.sample > tick.target;
    gap       = tick.target - tick.sample;
    diff      = gap[ldr_pkg::SAMPLE_W-1:3];
    step_upd  = step_r;
    if (overshoot) begin
      step_upd = ldr_pkg::STEP_MIN;
    end else if ((diff < {{(ldr_pkg::DIFF_W - ldr_pkg::STEP_W){1'b0}}, step_r}) &&
                 (diff != '0)) begin
      step_upd = diff[ldr_pkg::STEP_W-1:0];
    end
  end

  // Prediction: twice the present sample minus the oldest one, floored at zero
  always_comb begin
    pred_full = $signed({2'b00, tick.sample, 1'b0}) - $signed({3'b000, tick.past});
    pred      = pred_full[PRED_W-1] ? '0 : pred_full[PRED_W-2:0];
  end

  always_comb begin
    dac_down = $signed({1'b0, dac_r}) - $signed({{(SUM_W - ldr_pkg::STEP_W){1'b0}}, step_upd});
    dac_up   = {1'b0, dac_r} + {{(SUM_W - ldr_pkg::STEP_W){1'b0}}, step_upd};
    dac_upd  = dac_r;
    if ({2'b00, tick.target} > pred) begin
      dac_upd = (dac_down < $signed({1'b0, dac_floor})) ? dac_floor
                                                        : dac_down[ldr_pkg::DAC_W-1:0];
    end else if ({2'b00, tick.target} < pred) begin
      dac_upd = (dac_up > {1'b0, dac_ceiling}) ? dac_ceiling : dac_up[ldr_pkg::DAC_W-1:0];
    end
  end

  always_comb begin
    step_nxt = tick.advance ? step_upd : step_r;
    dac_nxt  = tick.advance ? dac_upd : dac_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ldr_pkg::STEP_RESET;
      dac_r  <= ldr_pkg::DAC_RESET;
    end else begin
      step_r <= step_nxt;
      dac_r  <= dac_nxt;
    end
  end

  `ASSERT_PROP(a_step_range, clk, rst_n, (step_r != '0) && (step_r <= ldr_pkg::STEP_RESET), "step size out of range")
  `ASSERT_NEXT(a_hold_idle, clk, rst_n, !tick.advance, $stable(dac_r) && $stable(step_r), "loop state moved without a tick")
  `ASSERT_NEXT(a_overshoot_step, clk, rst_n, tick.advance && overshoot, step_r == ldr_pkg::STEP_MIN, "overshoot did not reset step")

endmodule

// ----- tb/sv/led_current_dac_regulator_chk.sv -----
// Checker for the LED current DAC regulator: watches the configuration port and
// both channels, predicts each result word and compares it field by field.
// Depends on ldr_pkg, ldr_in_if and ldr_out_if.
module led_current_dac_regulator_chk
  import ldr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ldr_in_if                     in_mon,
  ldr_out_if                    out_mon,
  output int                    fail_count,
  output int                    outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOT_W = $clog2(LDR_HIST_DEPTH);

  typedef struct packed {
    logic [DAC_W-1:0] dac_code;
    logic             converter_enable;
    logic [1:0]       light_level;
  } drive_word_t;

  // Register copies
  logic [SAMPLE_W-1:0] tgt_one, tgt_two, tgt_three;
  logic [DAC_W-1:0]    dac_lo, dac_hi;

  // Regulator state
  logic [1:0]          level_now;
  logic                down_held, up_held;
  logic [STEP_W-1:0]   step_now;
  logic [SAMPLE_W-1:0] sample_ring [LDR_HIST_DEPTH];
  logic [SLOT_W-1:0]   ring_slot;
  int                  dac_now;

  drive_word_t dac_words_due[$];
  int          n_fail = 0;

  assign fail_count = n_fail;

  // One control tick: level, step size, prediction and DAC move; link down holds all, converter off.
  function automatic drive_word_t regulate_tick(logic link, logic down, logic up,
                                                logic [RAW_W-1:0] raw);
    drive_word_t         w;
    logic [SAMPLE_W-1:0] tgt, smp, past, gap;
    int                  pred;
    w.dac_code         = dac_now[DAC_W-1:0];
    w.converter_enable = 1'b0;
    w.light_level      = level_now;
    if (!link)
      return w;
    if (down && !down_held && level_now != LEVEL_OFF)
      level_now = level_now - 2'd1;
    if (up && !up_held && level_now != LEVEL_THREE)
      level_now = level_now + 2'd1;
    down_held = down;
    up_held   = up;
    case (level_now)
      LEVEL_ONE:   tgt = tgt_one;
      LEVEL_TWO:   tgt = tgt_two;
      LEVEL_THREE: tgt = tgt_three;
      default:     tgt = '0;
    endcase
    smp = raw[RAW_W-1] ? '0 : raw[SAMPLE_W-1:0];
    if (smp > tgt) begin
      step_now = STEP_MIN;
    end else begin
      gap = (tgt - smp) >> 3;
      if (gap != '0 && gap < {{(SAMPLE_W - STEP_W){1'b0}}, step_now})
        step_now = gap[STEP_W-1:0];
    end
    past = sample_ring[ring_slot];
    sample_ring[ring_slot] = smp;
    ring_slot = (ring_slot == SLOT_W'(LDR_HIST_DEPTH - 1)) ? '0 : ring_slot + 1'b1;
    pred = 2 * int'(smp) - int'(past);
    if (pred < 0)
      pred = 0;
    if (int'(tgt) > pred) begin
      dac_now = dac_now - int'(step_now);
      if (dac_now < int'(dac_lo))
        dac_now = int'(dac_lo);
    end
    if (int'(tgt) < pred) begin
      dac_now = dac_now + int'(step_now);
      if (dac_now > int'(dac_hi))
        dac_now = int'(dac_hi);
    end
    w.dac_code         = dac_now[DAC_W-1:0];
    w.converter_enable = (level_now != LEVEL_OFF);
    w.light_level      = level_now;
    return w;
  endfunction

  always @(posedge clk) begin : watch
    drive_word_t due;
    if (!rst_n) begin
      tgt_one     = TARGET1_RESET;
      tgt_two     = TARGET2_RESET;
      tgt_three   = TARGET3_RESET;
      dac_lo      = FLOOR_RESET;
      dac_hi      = CEILING_RESET;
      level_now   = LEVEL_OFF;
      down_held   = 1'b0;
      up_held     = 1'b0;
      step_now    = STEP_RESET;
      sample_ring = '{default: '0};
      ring_slot   = '0;
      dac_now     = int'(DAC_RESET);
      dac_words_due.delete();
    end else begin
      // a result leaves before the word accepted at this edge can have caused one
      if (out_mon.valid && out_mon.ready) begin
        if (dac_words_due.size() == 0) begin
          $error("result word with nothing expected: dac_code %0d", out_mon.dac_code);
          n_fail++;
        end else begin
          due = dac_words_due.pop_front();
          if (out_mon.dac_code !== due.dac_code) begin
            $error("dac_code: expected %0d, got %0d", due.dac_code, out_mon.dac_code);
            n_fail++;
          end
          if (out_mon.converter_enable !== due.converter_enable) begin
            $error("converter_enable: expected %0d, got %0d",
                   due.converter_enable, out_mon.converter_enable);
            n_fail++;
          end
          if (out_mon.light_level !== due.light_level) begin
            $error("light_level: expected %0d, got %0d",
                   due.light_level, out_mon.light_level);
            n_fail++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_ONE:   tgt_one   = cfg_wdata;
          CFG_TARGET_TWO:   tgt_two   = cfg_wdata;
          CFG_TARGET_THREE: tgt_three = cfg_wdata;
          CFG_DAC_FLOOR:    dac_lo    = cfg_wdata[DAC_W-1:0];
          CFG_DAC_CEILING:  dac_hi    = cfg_wdata[DAC_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        dac_words_due.push_back(regulate_tick(in_mon.link_ok, in_mon.level_down,
                                              in_mon.level_up, in_mon.current_sample));
    end
    outstanding <= dac_words_due.size();
  end

endmodule

// ----- tb/sv/led_current_dac_regulator_tb.sv -----
// Top of the LED current DAC regulator testbench: clock, reset, stimulus, verdict.
// Depends on ldr_pkg, ldr_in_if, ldr_out_if, the regulator RTL and
// led_current_dac_regulator_chk, which predicts and compares.
module led_current_dac_regulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ldr_pkg::*;

  localparam int WORDS_PER_PHASE = 155;
  localparam int N_PHASES        = 6;
  // First index past the register list; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int outstanding;

  // Idling controls: percentages of cycles lost on each side, and a hold-off count
  int tx_idle_pct  = 27;
  int rx_idle_pct  = 50;
  int rx_hold_left = 0;

  // Button levels as a user would hold them, and the targets now loaded
  logic                btn_down = 1'b0;
  logic                btn_up   = 1'b0;
  logic [SAMPLE_W-1:0] level_target [3];

  ldr_in_if  in_chan ();
  ldr_out_if out_chan ();

  led_current_dac_regulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan)
  );

  led_current_dac_regulator_chk chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #2 clk = ~clk;

  // Hard stop, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: a pending hold-off wins, otherwise drop ready at the set rate.
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_chan.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one tick word, idling first at the sender's rate, and hold it until taken.
  task automatic send_word(input logic link, input logic down, input logic up,
                           input logic [RAW_W-1:0] sample);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.link_ok        <= link;
    in_chan.level_down     <= down;
    in_chan.level_up       <= up;
    in_chan.current_sample <= sample;
    do begin
      @(posedge clk);
    end while (!in_chan.ready);
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (outstanding != 0);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Load all five registers, poke the unused indexes, and note the targets.
  task automatic load_settings(input logic [SAMPLE_W-1:0] t1, input logic [SAMPLE_W-1:0] t2,
                               input logic [SAMPLE_W-1:0] t3, input logic [DAC_W-1:0] lo,
                               input logic [DAC_W-1:0] hi);
    write_reg(CFG_TARGET_ONE, t1);
    write_reg(CFG_TARGET_TWO, t2);
    write_reg(CFG_TARGET_THREE, t3);
    write_reg(CFG_DAC_FLOOR, CFG_DATA_W'(lo));
    write_reg(CFG_DAC_CEILING, CFG_DATA_W'(hi));
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE + 3'd1, CFG_DATA_W'($urandom));
    write_reg(CFG_SPARE + 3'd2, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    level_target[0] = t1;
    level_target[1] = t2;
    level_target[2] = t3;
  endtask

  // Mostly samples around a live target, so the loop settles and hunts;
  // the rest small, negative or anything at all.
  function automatic logic [RAW_W-1:0] pick_sample();
    int r, v;
    r = $urandom_range(99);
    if (r < 55)
      v = int'(level_target[2'($urandom_range(2))]) + int'($urandom_range(128)) - 64;
    else if (r < 70)
      v = $urandom_range(300);
    else if (r < 82)
      v = -int'($urandom_range(32768, 1));
    else
      v = $urandom;
    return v[RAW_W-1:0];
  endfunction

  // Random ticks: buttons pressed and held like a user would, link mostly up.
  // A third of the way in, hold the receiver off so the block backs up;
  // two thirds in, pause the sender until everything has come back.
  task automatic run_random_words(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 3)
        rx_hold_left = 64;
      if (i == 2 * count / 3)
        drain_results();
      if ($urandom_range(99) < 9)
        btn_down = ~btn_down;
      if ($urandom_range(99) < 10)
        btn_up = ~btn_up;
      send_word($urandom_range(99) < 93, btn_down, btn_up, pick_sample());
    end
  endtask

  initial begin : stimulus
    int wait_left;
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = '0;
    cfg_wdata              = '0;
    in_chan.valid          = 1'b0;
    in_chan.link_ok        = 1'b0;
    in_chan.level_down     = 1'b0;
    in_chan.level_up       = 1'b0;
    in_chan.current_sample = '0;
    level_target[0]        = TARGET1_RESET;
    level_target[1]        = TARGET2_RESET;
    level_target[2]        = TARGET3_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks on the reset settings, while the step is still large.
    // Link lost with both buttons down: converter off, nothing moves, and no
    // edge is remembered.
    send_word(1'b0, 1'b1, 1'b1, 16'sh7FFF);
    // Up edge: level one, target zero
    send_word(1'b1, 1'b0, 1'b1, 16'sh0000);
    // Up still held: no further step
    send_word(1'b1, 1'b0, 1'b1, 16'sh0000);
    // Most negative sample is clamped to zero
    send_word(1'b1, 1'b0, 1'b0, 16'sh8000);
    // Level two; the gap is wide, so the step stays at its reset size
    send_word(1'b1, 1'b0, 1'b1, 16'sh0000);
    send_word(1'b1, 1'b0, 1'b0, 16'sd100);
    // Level three; a close sample shrinks the step
    send_word(1'b1, 1'b0, 1'b1, 16'sd200);
    send_word(1'b1, 1'b0, 1'b0, 16'sd7000);
    send_word(1'b1, 1'b0, 1'b0, 16'sd7200);
    // Up edge at the top: level stays; sample on target, prediction above it
    send_word(1'b1, 1'b0, 1'b1, 16'sd7350);
    send_word(1'b1, 1'b1, 1'b0, 16'sd7350);
    // Both released, then both rise together: down first, then up
    send_word(1'b1, 1'b0, 1'b0, 16'sd1500);
    send_word(1'b1, 1'b1, 1'b1, 16'sd1500);
    // Overshoot: step falls to one
    send_word(1'b1, 1'b0, 1'b0, 16'sh7FFF);
    send_word(1'b1, 1'b0, 1'b0, -16'sd1);
    // Step down to level zero and past it
    send_word(1'b1, 1'b1, 1'b0, 16'sd0);
    send_word(1'b1, 1'b0, 1'b0, 16'sd0);
    send_word(1'b1, 1'b1, 1'b0, 16'sd0);
    send_word(1'b1, 1'b0, 1'b0, 16'sd0);
    send_word(1'b1, 1'b1, 1'b0, 16'sd0);
    send_word(1'b1, 1'b0, 1'b0, 16'sd0);
    send_word(1'b1, 1'b1, 1'b0, 16'sd0);
    // Both rise together at level zero: down holds, up lifts to one
    send_word(1'b1, 1'b0, 1'b0, 16'sd0);
    send_word(1'b1, 1'b1, 1'b1, 16'sd1234);
    // Link lost mid-run: held level and code come back, converter off
    send_word(1'b0, 1'b0, 1'b0, 16'sd1234);

    // Random phases, each on its own settings; extremes among them.
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      case (p)
        0: load_settings(TARGET1_RESET, TARGET2_RESET, TARGET3_RESET,
                         FLOOR_RESET, CEILING_RESET);
        1: load_settings(15'd32767, 15'd32767, 15'd32767, 12'd0, 12'd4095);
        // floor above ceiling: each clamp acts on its own side
        2: load_settings(15'd0, 15'd0, 15'd0, 12'd4095, 12'd0);
        3: load_settings(15'd100, 15'd2000, 15'd20000, 12'd1000, 12'd1010);
        4: load_settings(SAMPLE_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                         DAC_W'($urandom_range(2047)), DAC_W'($urandom_range(4095, 2048)));
        default: load_settings(15'd1, SAMPLE_W'($urandom), 15'd32767, 12'd0, 12'd0);
      endcase
      // receiver lags first, then the sender, then neither side idles
      if (p < 2) begin
        tx_idle_pct = 27;
        rx_idle_pct = 50;
      end else if (p < 4) begin
        tx_idle_pct = 50;
        rx_idle_pct = 27;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_random_words(WORDS_PER_PHASE);
    end

    // Let the last words out, with a bound, then give the verdict
    in_chan.valid <= 1'b0;
    wait_left = 1000;
    do begin
      @(posedge clk);
      wait_left--;
    end while (outstanding != 0 && wait_left > 0);
    repeat (4) @(posedge clk);
    if (outstanding != 0)
      $error("%0d expected words never arrived", outstanding);
    if (fail_count == 0 && outstanding == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/ldr_pkg.sv
rtl/core/ldr_in_if.sv
rtl/core/ldr_out_if.sv
rtl/core/ldr_hist_cell.sv
rtl/core/ldr_dac_loop.sv
rtl/core/led_current_dac_regulator.sv
tb/sv/led_current_dac_regulator_chk.sv
tb/sv/led_current_dac_regulator_tb.sv
